FILE: hw/rtl/bppd_pkg.sv
// Shared types and constants for the button press pattern decoder.
`timescale 1ns / 1ps

package bppd_pkg;

	localparam int MAX_DIGITS = 4;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// configuration register indexes
	localparam logic [2:0] REG_DEBOUNCE_US = 3'd0;
	localparam logic [2:0] REG_GESTURE_US  = 3'd1;
	localparam logic [2:0] REG_SHORT_CODE  = 3'd2;
	localparam logic [2:0] REG_LONG_CODE   = 3'd3;
	localparam logic [2:0] REG_CODE_BASE   = 3'd4;

	localparam logic [31:0] DEBOUNCE_RST = 32'd50000;
	localparam logic [31:0] GESTURE_RST  = 32'd500000;
	localparam logic [7:0]  SHORT_RST    = 8'd1;
	localparam logic [7:0]  LONG_RST     = 8'd2;
	localparam logic [7:0]  BASE_RST     = 8'd3;

	// input kinds carried in tuser
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// button timing state machine
	typedef enum logic [4:0] {
		F_START   = 5'b00001,
		F_TIMING  = 5'b00010,
		F_SHORT   = 5'b00100,
		F_LONG    = 5'b01000,
		F_ANALYSE = 5'b10000
	} btn_state_t;

	// per-word sequencer
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEB  = 7'b0000010,
		S_FSM  = 7'b0000100,
		S_MD   = 7'b0001000,
		S_MW   = 7'b0010000,
		S_UW   = 7'b0100000,
		S_OUT  = 7'b1000000
	} seq_state_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
	} mul_req_t;

endpackage

FILE: hw/rtl/bppd_mul.sv
// Shared 8x8 multiplier, low byte of the product registered.
`timescale 1ns / 1ps

module bppd_mul (
	input  logic               clk,
	input  bppd_pkg::mul_req_t req,
	output logic [7:0]         prod_q
);

	logic [15:0] full;

	assign full = req.a * req.b;

	always_ff @(posedge clk) begin
		prod_q <= full[7:0];
	end

endmodule

FILE: hw/rtl/button_press_pattern_decoder_core.sv
// Top level: debouncer, press timing machine and digit analysis sequencer.
`timescale 1ns / 1ps
//
// Usage:
//   s_* : input words. tuser = cmd (0 sample tick, 1 read and clear).
//         tdata = {pad, pin_low, time_us}. One word is taken at a time.
//   m_* : one 8-bit gesture word per input word, in order.
//   cfg_*: register writes (index, data), always ready; write only while idle.
// Processing steps:
//   read command   : output step only, which loads the result register.
//   plain tick     : debounce compare, machine step, output.
//   analysis tick  : as a plain tick, plus multiply and sum steps per digit
//                    and a weight update between digits; the single
//                    shared 8x8 multiplier forms digit*weight and weight*base
//                    one after the other for each digit.
// The sequencer returns to idle, after any output stall, as the result
// register loads, so the next word can be taken in the following cycle.
// s_tready is high only while the sequencer is idle, so the next word may be
// taken while the previous result still sits in the output register.
// If the receiver stalls, the finished word waits in the sequencer's output
// step until the output register frees up; no result is dropped.
// Reset (arst_n low) restores register defaults, clears the debouncer,
// the timing machine, the digit count and the held gesture.

module button_press_pattern_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] time_us, [32] pin_low, [39:33] zero
	input  logic        s_tuser,   // [0] cmd
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] gesture
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW = bppd_pkg::CNT_W;
	localparam int IW = bppd_pkg::IDX_W;

	// config registers
	logic [31:0] debounce_us_q, gesture_us_q;
	logic [7:0]  short_code_q, long_code_q, code_base_q;

	// control state
	bppd_pkg::seq_state_t seq_q;
	bppd_pkg::btn_state_t fsm_q;
	logic          level_q, debouncing_q, rise_q, fall_q, cmd_q;
	logic [31:0]   change_time_q, mark_time_q;
	logic [CW-1:0] digit_count_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    held_q;
	logic          m_tvalid_q;

	// payload
	logic [31:0] now_q;
	logic        pin_q;
	logic [7:0]  sum_q, weight_q, m_tdata_q;
	logic [7:0]  digit_store [bppd_pkg::MAX_DIGITS];

	// shared multiplier
	bppd_pkg::mul_req_t mreq;
	logic [7:0]         prod_q;

	bppd_mul u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_q (prod_q)
	);

	always_comb begin
		if (seq_q == bppd_pkg::S_MD) begin
			mreq.a = digit_store[idx_q];
			mreq.b = weight_q;
		end else begin
			mreq.a = weight_q;
			mreq.b = code_base_q;
		end
	end

	// datapath compares
	logic [31:0] since_change, since_mark;
	logic        lock_over, gap_over, full, last_digit, out_free, accept;
	logic [7:0]  sum_next;

	assign since_change = now_q - change_time_q;
	assign since_mark   = now_q - mark_time_q;
	assign lock_over    = !debouncing_q || (since_change > debounce_us_q);
	assign gap_over     = since_mark > gesture_us_q;
	assign full         = digit_count_q >= CW'(bppd_pkg::MAX_DIGITS);
	assign last_digit   = (CW'(idx_q) + CW'(1)) == digit_count_q;
	assign sum_next     = sum_q + prod_q;
	assign out_free     = !m_tvalid_q || m_tready;

	assign s_tready  = (seq_q == bppd_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_us_q <= bppd_pkg::DEBOUNCE_RST;
			gesture_us_q  <= bppd_pkg::GESTURE_RST;
			short_code_q  <= bppd_pkg::SHORT_RST;
			long_code_q   <= bppd_pkg::LONG_RST;
			code_base_q   <= bppd_pkg::BASE_RST;
			seq_q         <= bppd_pkg::S_IDLE;
			fsm_q         <= bppd_pkg::F_START;
			level_q       <= 1'b0;
			debouncing_q  <= 1'b0;
			rise_q        <= 1'b0;
			fall_q        <= 1'b0;
			cmd_q         <= bppd_pkg::CMD_TICK;
			change_time_q <= '0;
			mark_time_q   <= '0;
			digit_count_q <= '0;
			idx_q         <= '0;
			held_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bppd_pkg::REG_DEBOUNCE_US: debounce_us_q <= cfg_data;
					bppd_pkg::REG_GESTURE_US:  gesture_us_q  <= cfg_data;
					bppd_pkg::REG_SHORT_CODE:  short_code_q  <= cfg_data[7:0];
					bppd_pkg::REG_LONG_CODE:   long_code_q   <= cfg_data[7:0];
					bppd_pkg::REG_CODE_BASE:   code_base_q   <= cfg_data[7:0];
					default: ;
				endcase
			end

			// output register: load from the output step, else drop on handshake
			if (seq_q == bppd_pkg::S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			case (seq_q)
				bppd_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q <= s_tuser;
						seq_q <= (s_tuser == bppd_pkg::CMD_READ) ? bppd_pkg::S_OUT
						                                         : bppd_pkg::S_DEB;
					end
				end
				bppd_pkg::S_DEB: begin
					// edges only when the lockout is over and the level moves
					rise_q <= lock_over && !level_q && pin_q;
					fall_q <= lock_over && level_q && !pin_q;
					if (lock_over) begin
						debouncing_q <= (level_q != pin_q);
						if (level_q != pin_q) change_time_q <= now_q;
						level_q <= pin_q;
					end
					seq_q <= bppd_pkg::S_FSM;
				end
				bppd_pkg::S_FSM: begin
					seq_q <= (fsm_q == bppd_pkg::F_ANALYSE && digit_count_q != '0)
					         ? bppd_pkg::S_MD : bppd_pkg::S_OUT;
					case (fsm_q)
						bppd_pkg::F_START: begin
							// a fresh fall resets the mark, so the gap cannot exceed
							if (full || (digit_count_q != '0 && !fall_q && gap_over))
								fsm_q <= bppd_pkg::F_ANALYSE;
							else if (fall_q)
								fsm_q <= bppd_pkg::F_TIMING;
							if (fall_q) mark_time_q <= now_q;
						end
						bppd_pkg::F_TIMING: begin
							if (rise_q)
								fsm_q <= gap_over ? bppd_pkg::F_LONG : bppd_pkg::F_SHORT;
						end
						bppd_pkg::F_SHORT, bppd_pkg::F_LONG: begin
							if (!full) digit_count_q <= digit_count_q + CW'(1);
							mark_time_q <= now_q;
							fsm_q       <= bppd_pkg::F_START;
						end
						bppd_pkg::F_ANALYSE: begin
							fsm_q <= bppd_pkg::F_START;
							idx_q <= '0;
							if (digit_count_q == '0) held_q <= '0;
						end
						default: fsm_q <= bppd_pkg::F_START;
					endcase
				end
				bppd_pkg::S_MD: seq_q <= bppd_pkg::S_MW;
				bppd_pkg::S_MW: begin
					if (last_digit) begin
						held_q        <= sum_next;
						digit_count_q <= '0;
						seq_q         <= bppd_pkg::S_OUT;
					end else begin
						seq_q <= bppd_pkg::S_UW;
					end
				end
				bppd_pkg::S_UW: begin
					idx_q <= idx_q + IW'(1);
					seq_q <= bppd_pkg::S_MD;
				end
				bppd_pkg::S_OUT: begin
					if (out_free) begin
						if (cmd_q == bppd_pkg::CMD_READ) held_q <= '0;
						seq_q <= bppd_pkg::S_IDLE;
					end
				end
				default: seq_q <= bppd_pkg::S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= s_tdata[31:0];
			pin_q <= s_tdata[32];
		end
		if (seq_q == bppd_pkg::S_FSM && !full &&
		    (fsm_q == bppd_pkg::F_SHORT || fsm_q == bppd_pkg::F_LONG)) begin
			digit_store[digit_count_q[IW-1:0]] <=
				(fsm_q == bppd_pkg::F_LONG) ? long_code_q : short_code_q;
		end
		if (seq_q == bppd_pkg::S_FSM) begin
			sum_q    <= '0;
			weight_q <= 8'd1;
		end
		if (seq_q == bppd_pkg::S_MW) sum_q    <= sum_next;
		if (seq_q == bppd_pkg::S_UW) weight_q <= prod_q;
		if (seq_q == bppd_pkg::S_OUT && out_free) m_tdata_q <= held_q;
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= CW'(bppd_pkg::MAX_DIGITS))
		else $error("digit count above capacity");

	a_mul_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == bppd_pkg::S_MD) |-> (digit_count_q != '0))
		else $error("analysis running with empty digit store");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second word taken while one is in work");

	a_out_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> m_tvalid_q && $stable(m_tdata_q))
		else $error("pending result overwritten");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the button press pattern decoder core.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 400;  // cycles with no handshake on any channel
	localparam int N_PHASES       = 10;
	localparam int PHASE_WORDS    = 150;  // random input words per register setting
	localparam int N_ROWS         = 24;
	localparam int TAIL_CYCLES    = 40;   // longest analysis plus output, with margin

	// one row of the directed table; typed_ok marks a result read off by hand
	typedef struct {
		logic        cmd;
		logic [31:0] stamp;
		logic        pin;
		bit          typed_ok;
		logic [7:0]  typed;
	} press_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	button_press_pattern_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor copy of the registers and of the decoder state
	// ------------------------------------------------------------------
	logic [31:0] p_debounce;
	logic [31:0] p_gesture;
	logic [7:0]  p_short;
	logic [7:0]  p_long;
	logic [7:0]  p_base;

	logic        p_level;
	logic        p_locked;    // debounce lockout running
	logic [31:0] p_change;    // time of last accepted level change
	bppd_pkg::btn_state_t p_fsm;
	logic [31:0] p_mark;
	logic [7:0]  p_digits [bppd_pkg::MAX_DIGITS];
	int          p_count;
	logic [7:0]  p_held;

	logic [7:0]  gesture_q [$];   // expected gesture words, oldest first
	int          errs;
	int          n_sent;
	bit          calm;            // both sides run without idle cycles
	logic [31:0] cur_time;        // button clock for generated presses
	int unsigned d_eff;           // debounce and threshold, clipped for stimulus
	int unsigned g_eff;
	press_row_t  press_rows [N_ROWS];

	int          m_hold;
	logic [7:0]  m_want;
	int          quiet;

	function automatic void reset_model();
		p_debounce = bppd_pkg::DEBOUNCE_RST;
		p_gesture  = bppd_pkg::GESTURE_RST;
		p_short    = bppd_pkg::SHORT_RST;
		p_long     = bppd_pkg::LONG_RST;
		p_base     = bppd_pkg::BASE_RST;
		p_level    = 1'b0;
		p_locked   = 1'b0;
		p_change   = '0;
		p_fsm      = bppd_pkg::F_START;
		p_mark     = '0;
		for (int i = 0; i < bppd_pkg::MAX_DIGITS; i++)
			p_digits[i] = '0;
		p_count    = 0;
		p_held     = '0;
	endfunction

	// Steps the decoder by one input word and returns the gesture word it emits.
	function automatic logic [7:0] predict_gesture(logic cmd, logic [31:0] stamp, logic pin);
		logic        rise;
		logic        fall;
		logic [7:0]  rd;
		int unsigned acc;
		int unsigned wt;
		int          i;
		rise = 1'b0;
		fall = 1'b0;
		if (cmd == bppd_pkg::CMD_READ) begin
			// read returns the value before the clear; machine does not move
			rd = p_held;
			p_held = '0;
			return rd;
		end
		// debounce: all differences wrap mod 2^32, strict compare
		if (!p_locked || (stamp - p_change) > p_debounce) begin
			p_locked = 1'b0;
			if (p_level != pin) begin
				p_change = stamp;
				p_locked = 1'b1;
				rise = pin;
				fall = !pin;
			end
			p_level = pin;
		end
		case (p_fsm)
			bppd_pkg::F_START: begin
				if (fall) begin
					p_fsm  = bppd_pkg::F_TIMING;
					p_mark = stamp;
				end
				// full store or end-of-sequence gap overrides the edge
				if (p_count >= bppd_pkg::MAX_DIGITS ||
				    (p_count != 0 && (stamp - p_mark) > p_gesture))
					p_fsm = bppd_pkg::F_ANALYSE;
			end
			bppd_pkg::F_TIMING: begin
				if (rise)
					p_fsm = ((stamp - p_mark) > p_gesture) ? bppd_pkg::F_LONG
					                                       : bppd_pkg::F_SHORT;
			end
			bppd_pkg::F_SHORT, bppd_pkg::F_LONG: begin
				if (p_count < bppd_pkg::MAX_DIGITS) begin
					p_digits[p_count] = (p_fsm == bppd_pkg::F_SHORT) ? p_short : p_long;
					p_count++;
				end
				p_mark = stamp;
				p_fsm  = bppd_pkg::F_START;
			end
			bppd_pkg::F_ANALYSE: begin
				acc = 0;
				wt  = 1;
				for (i = 0; i < p_count; i++) begin
					acc = (acc + p_digits[i] * wt) & 32'hFF;
					wt  = (wt * p_base) & 32'hFF;
				end
				p_held  = acc[7:0];
				p_count = 0;
				p_fsm   = bppd_pkg::F_START;
			end
			default: p_fsm = bppd_pkg::F_START;
		endcase
		return p_held;
	endfunction

	function automatic int idle_draw();
		return calm ? 0 : int'($urandom_range(0, 8));
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Offers one input word after a random gap; predicts once it is taken.
	task automatic send_word(logic cmd, logic [31:0] stamp, logic pin, bit typed_ok,
			logic [7:0] typed);
		int         gap;
		logic [7:0] pred;
		gap = idle_draw();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, pin, stamp};
		do @(posedge clk); while (!s_tready);
		pred = predict_gesture(cmd, stamp, pin);
		gesture_q.push_back(typed_ok ? typed : pred);
		n_sent++;
	endtask

	task automatic tick(logic pin, int unsigned dt);
		cur_time = cur_time + dt;
		send_word(bppd_pkg::CMD_TICK, cur_time, pin, 1'b0, '0);
	endtask

	// Holds off the input side until every outstanding gesture word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (gesture_q.size() != 0);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bppd_pkg::REG_DEBOUNCE_US: p_debounce = val;
			bppd_pkg::REG_GESTURE_US:  p_gesture  = val;
			bppd_pkg::REG_SHORT_CODE:  p_short    = val[7:0];
			bppd_pkg::REG_LONG_CODE:   p_long     = val[7:0];
			bppd_pkg::REG_CODE_BASE:   p_base     = val[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A burst of 1..5 release/press pairs with random short or long gaps and
	// occasional contact bounce, then the pin held down past the threshold so
	// the sequence is analysed. Five pairs overflow the store and force analysis.
	task automatic press_burst();
		int          presses;
		int unsigned dt;
		presses = $urandom_range(1, 5);
		repeat (presses) begin
			tick(1'b0, d_eff + 1 + $urandom_range(0, d_eff));
			if ($urandom_range(0, 3) == 0)
				tick(1'b1, $urandom_range(0, d_eff));   // bounce inside lockout
			if ($urandom_range(0, 1))
				dt = g_eff + 1 + $urandom_range(0, g_eff);
			else
				dt = $urandom_range(d_eff + 1, g_eff);
			tick(1'b1, dt);
			tick(1'b1, $urandom_range(1, d_eff + 1));   // lets the digit be stored
		end
		tick(1'b1, g_eff + 1 + $urandom_range(0, g_eff));
		tick(1'b1, $urandom_range(1, 1000));
		if ($urandom_range(0, 1))
			send_word(bppd_pkg::CMD_READ, $urandom(), $urandom_range(0, 1), 1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (gesture_q.size() == 0) begin
					errs++;
					$display("%0t: gesture word %0d with nothing expected", $realtime, m_tdata);
				end else begin
					m_want = gesture_q.pop_front();
					if (m_tdata !== m_want) begin
						errs++;
						$display("%0t: gesture mismatch, expected %0d, actual %0d",
							$realtime, m_want, m_tdata);
					end
				end
				m_hold = idle_draw();
			end
			if (m_hold > 0) begin
				m_tready <= 1'b0;
				m_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: any accepted word on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else if (quiet >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int          ph;
		int          first;
		int          pick;
		logic [31:0] stamp;
		logic [7:0]  sc;
		logic [7:0]  lc;
		logic [7:0]  cb;
		logic [31:0] deb;
		logic [31:0] gest;

		clk = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= bppd_pkg::CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= bppd_pkg::REG_DEBOUNCE_US;
		cfg_data  <= '0;
		errs   = 0;
		n_sent = 0;
		quiet  = 0;
		calm   = 1'b0;
		cur_time = '0;
		reset_model();

		// Directed table, reset register values (50 ms lockout, 500 ms threshold).
		// Release-to-press interval is what gets timed; holding the pin down
		// after the last press ends the sequence.
		press_rows = '{
			'{bppd_pkg::CMD_READ, 32'd0,          1'b0, 1'b1, 8'd0},  // after reset: none held
			'{bppd_pkg::CMD_TICK, 32'd0,          1'b0, 1'b0, 8'd0},  // idle level, no edge
			'{bppd_pkg::CMD_TICK, 32'd100,        1'b1, 1'b0, 8'd0},  // press, rising edge
			'{bppd_pkg::CMD_TICK, 32'd200,        1'b0, 1'b0, 8'd0},  // bounce, locked out
			'{bppd_pkg::CMD_TICK, 32'd60000,      1'b0, 1'b0, 8'd0},  // release, timing starts
			'{bppd_pkg::CMD_TICK, 32'd200000,     1'b1, 1'b0, 8'd0},  // press after 140 ms: short
			'{bppd_pkg::CMD_TICK, 32'd210000,     1'b1, 1'b0, 8'd0},  // short digit stored
			'{bppd_pkg::CMD_TICK, 32'd300000,     1'b0, 1'b0, 8'd0},  // release
			'{bppd_pkg::CMD_TICK, 32'd900000,     1'b1, 1'b0, 8'd0},  // press after 600 ms: long
			'{bppd_pkg::CMD_TICK, 32'd910000,     1'b1, 1'b0, 8'd0},  // long digit stored
			'{bppd_pkg::CMD_TICK, 32'd1500000,    1'b1, 1'b0, 8'd0},  // gap past threshold
			'{bppd_pkg::CMD_TICK, 32'd1500001,    1'b1, 1'b0, 8'd0},  // analysis: 1 + 2*3
			'{bppd_pkg::CMD_READ, 32'd0,          1'b0, 1'b1, 8'd7},  // read returns 7
			'{bppd_pkg::CMD_READ, 32'd0,          1'b0, 1'b1, 8'd0},  // cleared by the read
			'{bppd_pkg::CMD_TICK, 32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0},  // release at top of time
			'{bppd_pkg::CMD_TICK, 32'h0000_1000,  1'b1, 1'b0, 8'd0},  // wrapped, still locked
			'{bppd_pkg::CMD_TICK, 32'h0001_0000,  1'b1, 1'b0, 8'd0},  // press across the wrap
			'{bppd_pkg::CMD_TICK, 32'h0001_0010,  1'b1, 1'b0, 8'd0},  // short digit stored
			'{bppd_pkg::CMD_READ, 32'hFFFF_FFFF,  1'b1, 1'b1, 8'd0},  // time and pin ignored
			'{bppd_pkg::CMD_TICK, 32'h0001_C350,  1'b0, 1'b0, 8'd0},  // lockout exactly equal
			'{bppd_pkg::CMD_TICK, 32'h0001_C351,  1'b0, 1'b0, 8'd0},  // one past lockout
			'{bppd_pkg::CMD_TICK, 32'h0009_6471,  1'b1, 1'b0, 8'd0},  // interval equal to threshold
			'{bppd_pkg::CMD_TICK, 32'h0009_6480,  1'b1, 1'b0, 8'd0},  // stored as short
			'{bppd_pkg::CMD_READ, 32'd0,          1'b0, 1'b1, 8'd0}   // not analysed yet
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (press_rows[r])
			send_word(press_rows[r].cmd, press_rows[r].stamp, press_rows[r].pin,
				press_rows[r].typed_ok, press_rows[r].typed);

		for (ph = 0; ph < N_PHASES; ph++) begin
			// registers change only with the decoder idle
			drain_results();
			sc = $urandom_range(0, 255);
			lc = $urandom_range(0, 255);
			cb = $urandom_range(0, 255);
			case (ph)
				0: begin  // no lockout, threshold never exceeded, zero base
					deb = '0;
					gest = 32'hFFFF_FFFF;
					sc = 8'd0;
					lc = 8'd255;
					cb = 8'd0;
				end
				1: begin  // endless lockout, zero threshold
					deb = 32'hFFFF_FFFF;
					gest = '0;
					sc = 8'd255;
					lc = 8'd0;
					cb = 8'd255;
				end
				2: begin
					deb = $urandom_range(0, 300);
					gest = $urandom_range(400, 4000);
					cb = 8'd1;
				end
				default: begin
					deb = $urandom_range(0, 2000);
					gest = $urandom_range(100, 30000);
				end
			endcase
			set_reg(bppd_pkg::REG_DEBOUNCE_US, deb);
			set_reg(bppd_pkg::REG_GESTURE_US, gest);
			set_reg(bppd_pkg::REG_SHORT_CODE, ($urandom() & 32'hFFFF_FF00) | sc);
			set_reg(bppd_pkg::REG_LONG_CODE, ($urandom() & 32'hFFFF_FF00) | lc);
			set_reg(bppd_pkg::REG_CODE_BASE, ($urandom() & 32'hFFFF_FF00) | cb);

			d_eff = (deb > 32'd2000) ? 2000 : deb;
			g_eff = (gest > 32'd50000) ? 50000 : gest;
			// phase 2 runs its presses across the 32-bit time wrap
			cur_time = (ph == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom();
			calm = (ph % 3 == 2);
			first = n_sent;

			while (n_sent - first < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// stray sample at an arbitrary time
					stamp = $urandom();
					send_word(bppd_pkg::CMD_TICK, stamp, $urandom_range(0, 1), 1'b0, '0);
					cur_time = stamp;
				end else if (pick < 15) begin
					send_word(bppd_pkg::CMD_READ, $urandom(), $urandom_range(0, 1), 1'b0, '0);
				end else if (pick < 17) begin
					drain_results();
				end else begin
					press_burst();
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
